/* design/wam_pkg.sv */
// Shared widths and control structures for the windowed allele ratio mean block.
`timescale 1ns / 1ps

package wam_pkg;

    localparam int POS_W     = 32;
    localparam int READS_W   = 16;
    localparam int RATIO_W   = 17;
    localparam int IDX_W     = 6;
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;

    typedef struct packed {
        logic load;        // capture the input marker and start its ratio division
        logic wr_en;       // write position and ratio of the captured marker
        logic cen_cap;     // latch the centre position and clear the accumulator
        logic scan_issue;  // a scan read was issued this cycle
        logic mean_start;  // start the division of the window sum by its count
        logic out_load;    // load the result register
        logic out_last;    // the loaded result is the final one of the sample
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;    // the shared divider has a new quotient
        logic out_free;    // the result register can take a new result
    } t_dp_stat;

endpackage

/* design/wam_in_if.sv */
// Marker input channel: valid/ready handshake with one marker per transaction.
`timescale 1ns / 1ps

interface wam_in_if import wam_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic [READS_W-1:0] ref_count;
    logic [READS_W-1:0] alt_count;
    logic               last_marker;

    modport source (output valid, position, ref_count, alt_count, last_marker, input ready);
    modport sink   (input valid, position, ref_count, alt_count, last_marker, output ready);
endinterface

/* design/wam_out_if.sv */
// Result output channel: valid/ready handshake with one window mean per transaction.
`timescale 1ns / 1ps

interface wam_out_if import wam_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   marker_index;
    logic [RATIO_W-1:0] mean_ratio;
    logic               empty_window;
    logic               last_result;

    modport source (output valid, marker_index, mean_ratio, empty_window, last_result,
                    input ready);
    modport sink   (input valid, marker_index, mean_ratio, empty_window, last_result,
                    output ready);
endinterface

/* design/wam_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wam_div import wam_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [RATIO_W-1:0]   o_quot
);

    localparam int STEP_W = $clog2(DIV_NUM_W);
    localparam int REM_W  = DIV_DEN_W + 1;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [REM_W-1:0]     r_rem;
    logic [RATIO_W-1:0]   r_quo;

    logic [REM_W-1:0]     rem_sh;
    logic                 ge;

    // The remainder stays below the divisor, so one extra bit holds the shifted value.
    assign rem_sh = {r_rem[REM_W-2:0], r_num[DIV_NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[RATIO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* design/wam_dp.sv */
// Datapath: marker memories, ratio and mean division, window accumulator, result register.
`timescale 1ns / 1ps

module wam_dp import wam_pkg::*; #(
    parameter int MAX_MARKERS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_stat                       o_stat,
    input  logic [$clog2(MAX_MARKERS)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_MARKERS)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_MARKERS)-1:0] i_out_idx,
    input  logic                           i_cfg_we,
    input  logic [POS_W-1:0]               i_cfg_wdata,
    input  logic [POS_W-1:0]               i_position,
    input  logic [READS_W-1:0]             i_ref_count,
    input  logic [READS_W-1:0]             i_alt_count,
    wam_out_if.source                      o_out
);

    localparam int AW  = $clog2(MAX_MARKERS);
    localparam int CW  = $clog2(MAX_MARKERS + 1);
    localparam int SW  = RATIO_W + AW;
    localparam int RSW = RATIO_W + 1;

    logic [POS_W-1:0] pos_mem [MAX_MARKERS];
    logic [RSW-1:0]   rat_mem [MAX_MARKERS];

    logic [POS_W-1:0]   r_wd;
    logic [POS_W-1:0]   r_pos_in;
    logic               r_zero;
    logic [POS_W-1:0]   r_pos_rd;
    logic [RSW-1:0]     r_rat_rd;
    logic [POS_W-1:0]   r_centre;
    logic               r_acc_pend;
    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_cnt;
    logic               r_ovalid;
    logic [IDX_W-1:0]   r_oidx;
    logic [RATIO_W-1:0] r_omean;
    logic               r_oempty;
    logic               r_olast;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [RATIO_W-1:0]   div_quot;
    logic [POS_W:0]       diff;
    logic [POS_W-1:0]     gap;
    logic                 in_win;

    assign div_start = i_cmd.load | i_cmd.mean_start;
    assign div_num   = i_cmd.load ? {i_ref_count, {RATIO_W-1{1'b0}}} : DIV_NUM_W'(r_sum);
    assign div_den   = i_cmd.load ? (DIV_DEN_W'(i_ref_count) + DIV_DEN_W'(i_alt_count))
                                  : DIV_DEN_W'(r_cnt);

    wam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd <= '0;
        end else if (i_cfg_we) begin
            r_wd <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_in <= i_position;
            r_zero   <= (i_ref_count == '0) && (i_alt_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            pos_mem[i_wr_addr] <= r_pos_in;
            rat_mem[i_wr_addr] <= r_zero ? '0 : {1'b1, div_quot};
        end
        r_pos_rd <= pos_mem[i_rd_addr];
        r_rat_rd <= rat_mem[i_rd_addr];
    end

    assign diff   = {1'b0, r_pos_rd} - {1'b0, r_centre};
    assign gap    = diff[POS_W] ? (r_centre - r_pos_rd) : diff[POS_W-1:0];
    assign in_win = r_rat_rd[RSW-1] && (gap <= r_wd);

    // Read data of a scan address arrives in the cycle after the address was issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pend <= 1'b0;
        end else begin
            r_acc_pend <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cen_cap) begin
            r_centre <= r_pos_rd;
            r_sum    <= '0;
            r_cnt    <= '0;
        end else if (r_acc_pend && in_win) begin
            r_sum <= r_sum + SW'(r_rat_rd[RATIO_W-1:0]);
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oidx   <= IDX_W'(i_out_idx);
            r_omean  <= (r_cnt == '0) ? '0 : div_quot;
            r_oempty <= (r_cnt == '0);
            r_olast  <= i_cmd.out_last;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || o_out.ready;

    assign o_out.valid        = r_ovalid;
    assign o_out.marker_index = r_oidx;
    assign o_out.mean_ratio   = r_omean;
    assign o_out.empty_window = r_oempty;
    assign o_out.last_result  = r_olast;

endmodule

/* design/wam_ctrl.sv */
// Controller: sequences marker loading, the window scan and result emission.
`timescale 1ns / 1ps

module wam_ctrl import wam_pkg::*; #(
    parameter int MAX_MARKERS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_last,
    output logic                           o_in_ready,
    input  t_dp_stat                       i_stat,
    output t_dp_cmd                        o_cmd,
    output logic [$clog2(MAX_MARKERS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_MARKERS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_MARKERS)-1:0] o_out_idx
);

    localparam int AW = $clog2(MAX_MARKERS);
    localparam int CW = $clog2(MAX_MARKERS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDIV  = 4'd1;
    localparam logic [3:0] S_CEN   = 4'd2;
    localparam logic [3:0] S_CENW  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_MDIV  = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_m, n_m;
    logic          r_last, n_last;

    logic accept;
    logic full;
    logic k_last;
    logic m_last;

    assign accept = i_in_valid && o_in_ready;
    assign full   = r_count == CW'(MAX_MARKERS);
    assign k_last = (CW'(r_k) + CW'(1)) == r_count;
    assign m_last = (CW'(r_m) + CW'(1)) == r_count;

    assign o_in_ready = r_state == S_IDLE;
    assign o_rd_addr  = (r_state == S_CEN) ? r_k : r_m;
    assign o_wr_addr  = r_count[AW-1:0];
    assign o_out_idx  = r_k;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_m     = r_m;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // A marker beyond the store is dropped, but its last flag still counts.
                    if (!full) begin
                        o_cmd.load = 1'b1;
                        n_last     = i_last;
                        n_state    = S_RDIV;
                    end else if (i_last) begin
                        n_k     = '0;
                        n_state = S_CEN;
                    end
                end
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_en = 1'b1;
                    n_count     = r_count + CW'(1);
                    if (r_last) begin
                        n_k     = '0;
                        n_state = S_CEN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CEN: begin
                n_state = S_CENW;
            end
            S_CENW: begin
                o_cmd.cen_cap = 1'b1;
                n_m           = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (m_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_m = r_m + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.mean_start = 1'b1;
                n_state          = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = k_last;
                    if (k_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_CEN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_m     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_m     <= n_m;
            r_last  <= n_last;
        end
    end

endmodule

/* design/windowed_allele_ratio_mean.sv */
// Loading a marker runs the transaction, 32 steps of the shared divider and the write.
// Each result of a sample of n markers needs a scan over all n stored markers through the
// memory read port, then 32 divider steps for the mean.
// Results follow the transaction carrying last_marker; no marker is taken until the final one is loaded.
// Synchronous active-low reset clears the controller, the count, the window distance and the
// result valid; the marker memories need no clearing.
`timescale 1ns / 1ps

module windowed_allele_ratio_mean import wam_pkg::*; #(
    parameter int MAX_MARKERS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_wdata,
    wam_in_if.sink           i_in_ch,
    wam_out_if.source        o_out_ch
);

    localparam int AW = $clog2(MAX_MARKERS);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] out_idx;
    logic          in_ready;

    assign i_in_ch.ready = in_ready;

    wam_ctrl #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_last     (i_in_ch.last_marker),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_out_idx  (out_idx)
    );

    wam_dp #(
        .MAX_MARKERS (MAX_MARKERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .i_out_idx   (out_idx),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_position  (i_in_ch.position),
        .i_ref_count (i_in_ch.ref_count),
        .i_alt_count (i_in_ch.alt_count),
        .o_out       (o_out_ch)
    );

endmodule

/* design/wam_chk.sv */
// Port-level checker for the windowed allele ratio mean block, bound to the top level.
`timescale 1ns / 1ps

module wam_chk import wam_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_last,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [IDX_W-1:0]   i_out_idx,
    input logic [RATIO_W-1:0] i_out_mean,
    input logic               i_out_empty,
    input logic               i_out_last
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_idx) && $stable(i_out_mean)
             && $stable(i_out_empty) && $stable(i_out_last)))
        else $error("stalled result changed");

    // An empty window always reports a zero mean.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_empty) |-> (i_out_mean == '0))
        else $error("empty window with nonzero mean");

    // The transaction that closes a sample starts the result pass, so the next marker waits.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input ready right after the final marker");

    // While a result other than the final one is on offer, no marker is taken.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready before the final result");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind windowed_allele_ratio_mean wam_chk u_wam_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_last   (i_in_ch.last_marker),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_idx   (o_out_ch.marker_index),
    .i_out_mean  (o_out_ch.mean_ratio),
    .i_out_empty (o_out_ch.empty_window),
    .i_out_last  (o_out_ch.last_result)
);
